[rtl/conv3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared widths, register indexes, item codes and types of the 3x3
// zero-padded convolution core.
// ----------------------------------------------------------------------------
package conv3_pkg;

	// Line store geometry (widest supported row)
	localparam int LINE_DEPTH = 1024;
	localparam int COL_W      = $clog2(LINE_DEPTH);

	// Field and register widths
	localparam int PIX_W     = 8;
	localparam int LINE_W    = 2 * PIX_W;
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 12;
	localparam int ROW_W     = HEIGHT_W + 1;
	localparam int KROW_W    = 48;
	localparam int COEF_W    = 16;
	localparam int REG_IDX_W = 3;

	// Datapath widths: Q8.8 coefficient times pixel, row sums, total
	localparam int PROD_W = COEF_W + PIX_W + 1;
	localparam int RSUM_W = PROD_W + 2;
	localparam int ACC_W  = RSUM_W + 1;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

	// Input item codes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Reset values
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET   = WIDTH_W'(LINE_DEPTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET  = HEIGHT_W'(1);
	localparam logic [KROW_W-1:0]   KMID_RESET    = 48'h0000_0100_0000;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef pix_t [8:0]        win_t;
	typedef logic [KROW_W-1:0] krow_t;
	typedef krow_t [2:0]       kernel_t;

	// Which window rows and columns lie inside the frame, and end of frame
	typedef struct packed {
		logic [2:0] row_ok;
		logic [2:0] col_ok;
		logic       last;
	} pos_t;

endpackage
`default_nettype wire

[rtl/conv3_line_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3_line_buf
// Both line stores side by side in one memory word (upper row in the high
// byte), one write port and one registered read port.
// ----------------------------------------------------------------------------
module conv3_line_buf import conv3_pkg::*; (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [COL_W-1:0]  rd_addr,
	output logic      [LINE_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [COL_W-1:0]  wr_addr,
	input  wire logic [LINE_W-1:0] wr_data
);

	logic [LINE_W-1:0] mem_q [LINE_DEPTH];
	logic [LINE_W-1:0] rd_data_q;

	// Write one column
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one column, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

[rtl/conv3_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3_mac
// Nine masked coefficient products, three row sums, final sum with clamp to
// 0..255 and the output register. Three stages with valid/ready between.
// ----------------------------------------------------------------------------
module conv3_mac import conv3_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	output logic                  ready,
	input  wire win_t             win,
	input  wire pos_t             pos,
	input  wire kernel_t          kernel,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [PIX_W-1:0] pixel_out,
	output logic                  frame_last
);

	logic signed [COEF_W-1:0] coef [9];
	logic signed [PIX_W:0]    opnd [9];
	logic signed [PROD_W-1:0] prod [9];
	logic signed [PROD_W-1:0] prod_s2 [9];
	logic                     valid_s2;
	logic                     last_s2;
	logic signed [RSUM_W-1:0] rsum [3];
	logic signed [RSUM_W-1:0] rsum_s3 [3];
	logic                     valid_s3;
	logic                     last_s3;
	logic signed [ACC_W-1:0]  acc;
	logic [ACC_W-9:0]         acc_int;
	logic [PIX_W-1:0]         pix_clamped;
	logic                     out_valid_q;
	logic [PIX_W-1:0]         pixel_q;
	logic                     last_q;
	logic                     move_s2;
	logic                     move_s3;

	// Stage handshakes
	assign move_s3 = valid_s3 && (!out_valid_q || out_ready);
	assign move_s2 = valid_s2 && (!valid_s3 || move_s3);
	assign ready   = !valid_s2 || move_s2;

	// Mask neighbors outside the frame and multiply
	for (genvar gi = 0; gi < 3; gi++) begin : g_row
		for (genvar gj = 0; gj < 3; gj++) begin : g_col
			localparam int K = gi * 3 + gj;
			assign coef[K] = kernel[gi][COEF_W*gj +: COEF_W];
			assign opnd[K] = (pos.row_ok[gi] && pos.col_ok[gj]) ? {1'b0, win[K]} : '0;
			assign prod[K] = PROD_W'(coef[K]) * PROD_W'(opnd[K]);
		end
	end

	// Sum each kernel row
	for (genvar gr = 0; gr < 3; gr++) begin : g_rsum
		assign rsum[gr] = RSUM_W'(prod_s2[3*gr]) + RSUM_W'(prod_s2[3*gr+1])
			+ RSUM_W'(prod_s2[3*gr+2]);
	end

	// Total, truncate the fraction, clamp to pixel range
	assign acc     = ACC_W'(rsum_s3[0]) + ACC_W'(rsum_s3[1]) + ACC_W'(rsum_s3[2]);
	assign acc_int = acc[ACC_W-1:8];
	always_comb begin
		if (acc[ACC_W-1]) begin
			pix_clamped = '0;
		end else if (acc_int[ACC_W-9:PIX_W] != '0) begin
			pix_clamped = '1;
		end else begin
			pix_clamped = acc_int[PIX_W-1:0];
		end
	end

	// Control of the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
			end else if (move_s2) begin
				valid_s2 <= 1'b0;
			end
			if (move_s2) begin
				valid_s3 <= 1'b1;
			end else if (move_s3) begin
				valid_s3 <= 1'b0;
			end
			if (move_s3) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload of the three stages
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2 <= prod;
			last_s2 <= pos.last;
		end
		if (move_s2) begin
			rsum_s3 <= rsum;
			last_s3 <= last_s2;
		end
		if (move_s3) begin
			pixel_q <= pix_clamped;
			last_q  <= last_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_q;
	assign frame_last = last_q;

endmodule
`default_nettype wire

[rtl/conv2d_3x3_zero_pad_clamp_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv2d_3x3_zero_pad_clamp_core
// 3x3 convolution with zero padding over a raster stream of 8-bit grey
// pixels; signed Q8.8 kernel, result truncated and clamped to 0..255.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------
//   in      | in_valid / in_ready  | op, pixel_in
//   out     | out_valid / out_ready| pixel_out, frame_last
//   cfg     | cfg_write            | cfg_index, cfg_data
//
// One item per clock while in_ready is high. The item that releases a result
// passes the input register with line store read, the products, the row sums,
// then the clamp into the output register.
// The first result of a frame follows image_width+1 pixel items.
// Reset clears counters, window and stage valids; the line stores are not
// cleared, entries never written feed only padded neighbors.
// Each stage holds while the next is full; in_ready drops only when the
// input stage holds an item that cannot move on.
// ----------------------------------------------------------------------------
module conv2d_3x3_zero_pad_clamp_core import conv3_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 op,
	input  wire logic [PIX_W-1:0]     pixel_in,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [PIX_W-1:0]     pixel_out,
	output logic                      frame_last,
	input  wire logic                 cfg_write,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [KROW_W-1:0]    cfg_data
);

	// Configuration
	logic [WIDTH_W-1:0]  cfg_width_q;
	logic [HEIGHT_W-1:0] cfg_height_q;
	kernel_t             kernel_q;
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;

	// Position counters
	logic [COL_W-1:0]    in_col_q;
	logic [ROW_W-1:0]    in_row_q;
	logic [COL_W-1:0]    out_col_q;
	logic [HEIGHT_W-1:0] out_row_q;

	// Accept decode
	logic               accept;
	logic               tail;
	logic               take;
	logic               produce;
	logic [WIDTH_W-1:0] in_col_inc;
	logic               in_col_end;
	logic [WIDTH_W-1:0] out_col_inc;
	logic [ROW_W-1:0]   out_row_inc;
	logic               out_col_end;
	logic               out_row_end;
	pos_t               pos;

	// Input stage
	logic              valid_s1;
	logic              produce_s1;
	logic [PIX_W-1:0]  pixel_s1;
	logic [COL_W-1:0]  addr_s1;
	pos_t              pos_s1;
	logic              byp_s1;
	logic [LINE_W-1:0] byp_data_s1;
	logic              s1_move;

	// Line stores and window
	logic [LINE_W-1:0] rd_data;
	logic [LINE_W-1:0] line_rd;
	logic [LINE_W-1:0] wr_data;
	logic [PIX_W-1:0]  top;
	logic [PIX_W-1:0]  mid;
	win_t              win_q;
	win_t              win_nx;

	logic mac_load;
	logic mac_ready;

	// Effective frame size
	always_comb begin
		if (cfg_width_q == '0) begin
			w_eff = WIDTH_W'(1);
		end else if (cfg_width_q > WIDTH_W'(LINE_DEPTH)) begin
			w_eff = WIDTH_W'(LINE_DEPTH);
		end else begin
			w_eff = cfg_width_q;
		end
		h_eff = (cfg_height_q == '0) ? HEIGHT_W'(1) : cfg_height_q;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= WIDTH_RESET;
			cfg_height_q <= HEIGHT_RESET;
			kernel_q[0]  <= '0;
			kernel_q[1]  <= KMID_RESET;
			kernel_q[2]  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   cfg_width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT:  cfg_height_q <= cfg_data[HEIGHT_W-1:0];
				REG_KERNEL_TOP:    kernel_q[0]  <= cfg_data;
				REG_KERNEL_MIDDLE: kernel_q[1]  <= cfg_data;
				REG_KERNEL_BOTTOM: kernel_q[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Accept: drop drain ticks inside the frame, zero pixels in the tail
	assign in_ready = !valid_s1 || s1_move;
	assign accept   = in_valid && in_ready;
	assign tail     = in_row_q >= {1'b0, h_eff};
	assign take     = accept && (tail || op == OP_PIXEL);

	// An item releases a result once w+1 items have gone before it
	assign produce = (in_row_q >= ROW_W'(2))
		|| (in_row_q == ROW_W'(1) && in_col_q != '0)
		|| (in_row_q == '0 && {1'b0, in_col_q} >= w_eff + WIDTH_W'(1));

	assign in_col_inc  = {1'b0, in_col_q} + WIDTH_W'(1);
	assign in_col_end  = in_col_inc >= w_eff;
	assign out_col_inc = {1'b0, out_col_q} + WIDTH_W'(1);
	assign out_row_inc = {1'b0, out_row_q} + ROW_W'(1);
	assign out_col_end = out_col_inc >= w_eff;
	assign out_row_end = out_row_inc >= {1'b0, h_eff};

	// Padding masks of the output position
	always_comb begin
		pos.row_ok = {!out_row_end, 1'b1, out_row_q != '0};
		pos.col_ok = {!out_col_end, 1'b1, out_col_q != '0};
		pos.last   = out_row_end && out_col_end;
	end

	// Advance positions; restart all at the end of the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (produce && pos.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_inc[COL_W-1:0];
				end
				if (produce) begin
					if (out_col_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_inc[HEIGHT_W-1:0];
					end else begin
						out_col_q <= out_col_inc[COL_W-1:0];
					end
				end
			end
		end
	end

	// Input stage: an item without result leaves at once
	assign s1_move  = valid_s1 && (!produce_s1 || mac_ready);
	assign mac_load = s1_move && produce_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// Forward the column written in the same cycle as the read
	always_ff @(posedge clk) begin
		if (take) begin
			produce_s1  <= produce;
			pixel_s1    <= tail ? '0 : pixel_in;
			addr_s1     <= in_col_q;
			pos_s1      <= pos;
			byp_s1      <= s1_move && (addr_s1 == in_col_q);
			byp_data_s1 <= wr_data;
		end
	end

	conv3_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (take),
		.rd_addr (in_col_q),
		.rd_data (rd_data),
		.wr_en   (s1_move),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	// Shift the line stores down one row at this column
	assign line_rd = byp_s1 ? byp_data_s1 : rd_data;
	assign top     = line_rd[LINE_W-1:PIX_W];
	assign mid     = line_rd[PIX_W-1:0];
	assign wr_data = {mid, pixel_s1};

	// Shift the window left, new column on the right
	always_comb begin
		win_nx[0] = win_q[1];
		win_nx[1] = win_q[2];
		win_nx[2] = top;
		win_nx[3] = win_q[4];
		win_nx[4] = win_q[5];
		win_nx[5] = mid;
		win_nx[6] = win_q[7];
		win_nx[7] = win_q[8];
		win_nx[8] = pixel_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_move) begin
			win_q <= win_nx;
		end
	end

	conv3_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (mac_load),
		.ready      (mac_ready),
		.win        (win_nx),
		.pos        (pos_s1),
		.kernel     (kernel_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.frame_last (frame_last)
	);

`ifndef SYNTHESIS
	// The multiply stage is loaded only when it has room
	a_mac_room: assert property (@(posedge clk) disable iff (!arst_n)
		mac_load |-> mac_ready)
		else $error("item loaded into a full multiply stage");

	// The last result of a frame restarts every position counter
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && produce && pos.last |=>
			in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0)
		else $error("positions not cleared after the end of the frame");

	// Items in the tail carry a zero pixel
	a_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		take && tail |=> pixel_s1 == '0)
		else $error("tail item carries a nonzero pixel");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_conv2d_3x3_zero_pad_clamp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_3x3_zero_pad_clamp_core
// Self-checking bench for the 3x3 zero-padded convolution core. A queue-fed
// driver streams pixel and drain items with random gaps, a monitor takes
// results under random stalls, and an in-bench model of the line stores,
// window and Q8.8 kernel predicts every output pixel. Covers tiny frames,
// a wide row, a tall frame, degenerate sizes and extreme kernels.
// ----------------------------------------------------------------------------
module tb_conv2d_3x3_zero_pad_clamp_core;
	import conv3_pkg::*;

	localparam longint LIMIT_NS     = 40_000_000;
	localparam int     SETTLE_BOUND = 1_000_000;
	localparam int     TAIL_CYCLES  = 8;
	localparam int     ITEM_BUDGET  = 1650;
	localparam int     MAX_REPORTS  = 40;

	typedef struct {
		logic             op;
		logic [PIX_W-1:0] pix;
	} stream_item_t;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic             last;
	} out_pixel_t;

	// DUT ports
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 op        = OP_PIXEL;
	logic [PIX_W-1:0]     pixel_in  = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PIX_W-1:0]     pixel_out;
	logic                 frame_last;
	logic                 cfg_write = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [KROW_W-1:0]    cfg_data  = '0;

	// Model of the core: registers, line stores, window and positions
	logic [WIDTH_W-1:0]  width_reg   = WIDTH_RESET;
	logic [HEIGHT_W-1:0] height_reg  = HEIGHT_RESET;
	logic [KROW_W-1:0]   kernel_rows [3] = '{48'h0, KMID_RESET, 48'h0};
	logic [PIX_W-1:0]    upper_line [LINE_DEPTH];
	logic [PIX_W-1:0]    lower_line [LINE_DEPTH];
	logic [PIX_W-1:0]    window [9];
	int unsigned         in_col, in_row, out_col, out_row;

	// Stimulus, expectations and bookkeeping
	stream_item_t pixel_stream [$];
	out_pixel_t   expected_pixels [$];
	stream_item_t next_item;
	out_pixel_t   head_pixel;
	bit           in_gaps_on    = 1'b0;
	bit           out_stalls_on = 1'b0;
	int unsigned  gap_left, hold_left;
	int unsigned  fail_count, accepted_items, checked_pixels, frames_done;
	int unsigned  stream_count;

	conv2d_3x3_zero_pad_clamp_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.frame_last(frame_last),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short idles, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic int unsigned eff_width(input logic [WIDTH_W-1:0] w);
		if (w == 0) return 1;
		if (w > LINE_DEPTH) return LINE_DEPTH;
		return w;
	endfunction

	function automatic int unsigned eff_height(input logic [HEIGHT_W-1:0] h);
		return (h == 0) ? 1 : h;
	endfunction

	function automatic logic [KROW_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[KROW_W-1:0];
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15) return '0;
		if (r < 25) return 16'h7FFF;
		if (r < 35) return 16'h8000;
		if (r < 45) return 16'h0100;
		if (r < 80) return COEF_W'(int'($urandom_range(0, 1024)) - 512);
		return COEF_W'($urandom());
	endfunction

	function automatic logic [KROW_W-1:0] rand_kernel_row();
		return {rand_coef(), rand_coef(), rand_coef()};
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	// Predict the result, if any, of one accepted item and advance the model
	task automatic convolve_item(input logic item_op, input logic [PIX_W-1:0] item_pix);
		int unsigned             w, h, c;
		int                      r, i, j;
		longint unsigned         k;
		longint                  acc;
		logic [PIX_W-1:0]        v, top, mid, clamped;
		logic [2:0]              row_in, col_in;
		logic signed [COEF_W-1:0] coef;
		logic                    is_last;
		w = eff_width(width_reg);
		h = eff_height(height_reg);
		// drop drain ticks while the frame is still arriving
		if (in_row < h && item_op == OP_DRAIN) return;
		v = (in_row >= h) ? '0 : item_pix;
		c = in_col;
		top = upper_line[c];
		mid = lower_line[c];
		upper_line[c] = mid;
		lower_line[c] = v;
		for (r = 0; r < 3; r++) begin
			window[r * 3]     = window[r * 3 + 1];
			window[r * 3 + 1] = window[r * 3 + 2];
		end
		window[2] = top;
		window[5] = mid;
		window[8] = v;
		k = longint'(in_row) * w + in_col;
		if (in_col + 1 >= w) begin
			in_col = 0;
			in_row++;
		end else begin
			in_col++;
		end
		if (k < w + 1) return;

		// sum in-frame neighbors only, then truncate and clamp
		row_in = {out_row + 1 < h, 1'b1, out_row > 0};
		col_in = {out_col + 1 < w, 1'b1, out_col > 0};
		acc = 0;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				if (row_in[i] && col_in[j]) begin
					coef = kernel_rows[i][j * COEF_W +: COEF_W];
					acc += longint'(coef) * longint'(window[i * 3 + j]);
				end
			end
		end
		if (acc < 0)
			clamped = '0;
		else if ((acc >>> 8) > 255)
			clamped = '1;
		else
			clamped = PIX_W'(acc >>> 8);

		is_last = (out_row + 1 >= h) && (out_col + 1 >= w);
		if (is_last) begin
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
		expected_pixels.push_back('{pix: clamped, last: is_last});
	endtask

	// Driver: present queued items, hold each until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op       <= OP_PIXEL;
			pixel_in <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				convolve_item(op, pixel_in);
				accepted_items++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pixel_stream.size() != 0) begin
					next_item = pixel_stream.pop_front();
					in_valid <= 1'b1;
					op       <= next_item.op;
					pixel_in <= next_item.pix;
					gap_left <= in_gaps_on ? idle_len() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, compare each result with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("%0t: output pixel %0d (frame_last %0b) with none expected",
							$time, pixel_out, frame_last);
					fail_count++;
				end else begin
					head_pixel = expected_pixels.pop_front();
					if (pixel_out !== head_pixel.pix) begin
						if (fail_count < MAX_REPORTS)
							$display("%0t: pixel_out expected %0d, got %0d",
								$time, head_pixel.pix, pixel_out);
						fail_count++;
					end
					if (frame_last !== head_pixel.last) begin
						if (fail_count < MAX_REPORTS)
							$display("%0t: frame_last expected %0b, got %0b",
								$time, head_pixel.last, frame_last);
						fail_count++;
					end
					checked_pixels++;
					if (head_pixel.last) frames_done++;
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (out_stalls_on && $urandom_range(0, 3) == 0) begin
				hold_left <= idle_len();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Register write; the model follows at once since the core is idle
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [KROW_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_IMAGE_WIDTH:   width_reg      = val[WIDTH_W-1:0];
			REG_IMAGE_HEIGHT:  height_reg     = val[HEIGHT_W-1:0];
			REG_KERNEL_TOP:    kernel_rows[0] = val;
			REG_KERNEL_MIDDLE: kernel_rows[1] = val;
			REG_KERNEL_BOTTOM: kernel_rows[2] = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Size registers, with junk above the used bits
	task automatic set_geometry(input int unsigned w, input int unsigned h);
		logic [KROW_W-1:0] val;
		val = rand48();
		val[WIDTH_W-1:0] = w[WIDTH_W-1:0];
		write_reg(REG_IMAGE_WIDTH, val);
		val = rand48();
		val[HEIGHT_W-1:0] = h[HEIGHT_W-1:0];
		write_reg(REG_IMAGE_HEIGHT, val);
	endtask

	task automatic set_kernel(input logic [KROW_W-1:0] top, mid, bot);
		write_reg(REG_KERNEL_TOP, top);
		write_reg(REG_KERNEL_MIDDLE, mid);
		write_reg(REG_KERNEL_BOTTOM, bot);
	endtask

	task automatic push_item(input logic item_op, input logic [PIX_W-1:0] pix);
		pixel_stream.push_back('{op: item_op, pix: pix});
		stream_count++;
	endtask

	// One full frame plus its tail; noise adds ignored drains and zeroed tail pixels
	task automatic queue_frame(input int unsigned w, input int unsigned h, input bit noisy);
		int unsigned i;
		for (i = 0; i < w * h; i++) begin
			if (noisy && $urandom_range(0, 11) == 0) push_item(OP_DRAIN, rand_pixel());
			push_item(OP_PIXEL, rand_pixel());
		end
		for (i = 0; i <= w; i++) begin
			if (noisy && $urandom_range(0, 4) == 0)
				push_item(OP_PIXEL, rand_pixel());
			else
				push_item(OP_DRAIN, rand_pixel());
		end
		if (noisy && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) push_item(OP_DRAIN, rand_pixel());
		end
	endtask

	// Wait until every item is taken and every result is back, then let the pipe empty
	task automatic settle();
		int unsigned spins;
		spins = 0;
		while ((pixel_stream.size() != 0 || in_valid || expected_pixels.size() != 0)
			&& spins < SETTLE_BOUND) begin
			@(negedge clk);
			spins++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	initial begin
		int unsigned i, wsel, hsel, w, h;
		foreach (upper_line[i]) begin
			upper_line[i] = '0;
			lower_line[i] = '0;
		end
		foreach (window[i]) window[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Degenerate sizes: drain while idle, width and height 0 act as 1
		push_item(OP_DRAIN, 8'h5A);
		settle();
		set_geometry(0, 0);
		set_kernel(48'h0, 48'h0000_7FFF_0000, 48'h0);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_PIXEL, 8'h07);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_DRAIN, 8'h00);
		settle();

		// Extreme coefficients on a checkerboard: both clamp limits
		in_gaps_on    = 1'b1;
		out_stalls_on = 1'b1;
		set_geometry(3, 2);
		set_kernel(48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 48'h7FFF_8000_7FFF);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_PIXEL, 8'h00);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_DRAIN, 8'hFF);
		push_item(OP_PIXEL, 8'h00);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_PIXEL, 8'h00);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_PIXEL, 8'h80);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_DRAIN, 8'h00);
		settle();

		// Change kernel and shrink height in the middle of a frame
		set_geometry(3, 4);
		set_kernel(48'h0040_0080_0040, 48'h0080_0100_0080, 48'h0040_0080_0040);
		for (i = 0; i < 5; i++) push_item(OP_PIXEL, rand_pixel());
		settle();
		write_reg(REG_KERNEL_TOP, 48'hFF80_FF00_FF80);
		set_geometry(3, 2);
		push_item(OP_PIXEL, rand_pixel());
		for (i = 0; i < 4; i++) push_item(OP_DRAIN, rand_pixel());
		settle();

		// A wider row and a taller frame than the random mix reaches
		set_geometry(130, 2);
		set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
		queue_frame(eff_width(width_reg), eff_height(height_reg), 1'b1);
		settle();
		out_stalls_on = 1'b0;
		set_geometry(1, 200);
		set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
		queue_frame(eff_width(width_reg), eff_height(height_reg), 1'b1);
		settle();

		// Random small frames with random kernels and idling
		while (stream_count < ITEM_BUDGET) begin
			in_gaps_on    = $urandom_range(0, 3) != 0;
			out_stalls_on = $urandom_range(0, 3) != 0;
			wsel = $urandom_range(0, 99);
			hsel = $urandom_range(0, 99);
			if (wsel < 5)       w = 0;
			else if (wsel < 70) w = $urandom_range(1, 8);
			else if (wsel < 95) w = $urandom_range(9, 40);
			else                w = $urandom_range(41, 96);
			if (hsel < 5)       h = 0;
			else if (hsel < 80) h = $urandom_range(1, 6);
			else                h = $urandom_range(7, 16);
			set_geometry(w, h);
			if ($urandom_range(0, 3) != 0)
				set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
			repeat ($urandom_range(1, 3))
				queue_frame(eff_width(width_reg), eff_height(height_reg), 1'b1);
			settle();
		end

		settle();
		if (expected_pixels.size() != 0) begin
			$display("%0t: %0d expected output pixels never arrived",
				$time, expected_pixels.size());
			fail_count++;
		end
		$display("Streamed %0d items, compared %0d output pixels across %0d frames.",
			accepted_items, checked_pixels, frames_done);
		$display("Frames ran from 1x1 up to 130 wide and 200 tall, with random and extreme kernels.");
		if (fail_count == 0) begin
			$display("tb_conv2d_3x3_zero_pad_clamp_core OK");
		end else begin
			$display("tb_conv2d_3x3_zero_pad_clamp_core NOT OK");
		end
		$finish;
	end

	// Hard stop for a hung run
	initial begin
		#(LIMIT_NS);
		$display("tb_conv2d_3x3_zero_pad_clamp_core NOT OK");
		$finish;
	end

endmodule
